// ----- sv/vertex_2d_transform_macros.svh -----
// Assertion macros for the vertex transform block.
`ifndef VERTEX_2D_TRANSFORM_MACROS_SVH
`define VERTEX_2D_TRANSFORM_MACROS_SVH

`ifndef SYNTH
`define V2DT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("v2dt assertion failed");
`define V2DT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("v2dt assertion failed");
`else
`define V2DT_ASSERT_IMPL(name, clk, rst, ante, cons)
`define V2DT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- sv/v2dt_pkg.sv -----
// Package with mode codes, register indexes and the first-quadrant sine table.
package v2dt_pkg;

   typedef enum logic [2:0] {
      MODE_TRANSLATE = 3'd0,
      MODE_SCALE     = 3'd1,
      MODE_ROTATE    = 3'd2,
      MODE_REFLECT_H = 3'd3,
      MODE_REFLECT_V = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MODE    = 2'd0,
      CSR_PARAM_X = 2'd1,
      CSR_PARAM_Y = 2'd2,
      CSR_ANGLE   = 2'd3
   } csr_index_type;

   localparam logic [63:0] PI_Q31  = 64'd6746518852;
   localparam logic [63:0] Q31_ONE = 64'd2147483648;

   typedef logic [63:0] div_list_type [0:5];
   localparam div_list_type SIN_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
   localparam div_list_type COS_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};

   typedef logic [31:0] sin_table_type [0:90];

   // Q31 sine of q degrees, q in 0..90, by truncated Taylor series
   function automatic logic [31:0] sin_q31(input int unsigned q);
      logic        use_cos;
      int unsigned r;
      logic [63:0] x;
      logic [63:0] term;
      longint      sum;
      use_cos = (q > 45);
      r = use_cos ? (90 - q) : q;
      x = (64'(r) * PI_Q31) / 180;
      term = use_cos ? Q31_ONE : x;
      sum = longint'(term);
      for (int n = 0; n < 6; n++) begin
         term = (((term * x) >> 31) * x) >> 31;
         if (use_cos) begin
            term = term / COS_DIV[n];
         end else begin
            term = term / SIN_DIV[n];
         end
         if ((n % 2) == 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return sum[31:0];
   endfunction

   function automatic sin_table_type build_sin_table();
      sin_table_type t;
      for (int q = 0; q <= 90; q++) begin
         t[q] = sin_q31(q);
      end
      return t;
   endfunction

   localparam sin_table_type SIN_Q31 = build_sin_table();

endpackage

// ----- sv/vertex_2d_transform.sv -----
// Top level: 2D vertex transform (translate, scale, rotate, reflect) with saturation.
//
// Usage:
//   Vertices enter on the req_ channel (req_vx, req_vy) and results leave on the
//   rsp_ channel (rsp_out_x, rsp_out_y, rsp_saturated), both valid/ready.
//   One result transaction is produced per vertex transaction, in order.
//   A vertex accepted on req_ is stored in the input register, and the transform logic
//   loads the result register from it once the result register is empty or being taken.
//   Throughput is one vertex per cycle unless the receiver stalls; the four rotation
//   products and the scale products are computed in parallel in the single logic stage.
//   The configuration registers (mode, param_x, param_y, angle_deg) sit on an
//   APB-style port at byte addresses 0, 4, 8, 12. Writing angle_deg also loads
//   the sine and cosine registers from the quadrant-folded table.
//   Reset empties the pipeline, zeroes the config and sine registers (translate by zero) and sets cosine to one.
//   When the receiver stalls, the result register holds and the input register
//   keeps taking one more vertex; after that req_ready drops until rsp_ready.
module vertex_2d_transform #(
   parameter int COORD_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_vx,
   input  logic signed [COORD_BITS-1:0] req_vy,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic                         rsp_saturated,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [3:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

`include "vertex_2d_transform_macros.svh"

   localparam int W         = COORD_BITS;
   localparam int F         = TRIG_FRAC_BITS;
   localparam int WIDE      = 2 * W + 2;
   localparam int DX_BITS   = W + 1;
   localparam int PROD_BITS = W + F + 3;
   localparam int SUM_BITS  = W + F + 4;

   localparam logic signed [WIDE-1:0] COORD_MAX = {{(WIDE-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [WIDE-1:0] COORD_MIN = {{(WIDE-W+1){1'b1}}, {(W-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0] CEIL_BIAS = {{(SUM_BITS-F){1'b0}}, {F{1'b1}}};
   localparam logic signed [F+1:0] TRIG_ONE = {2'b01, {F{1'b0}}};

   // signed sine of d degrees, d in 0..359, with F fraction bits
   function automatic logic signed [F+1:0] trig_sin(input logic [8:0] d);
      logic [8:0]  q;
      logic        neg;
      logic [63:0] rounded;
      logic [F:0]  mag;
      neg = 1'b0;
      if (d <= 9'd90) begin
         q = d;
      end else if (d <= 9'd180) begin
         q = 9'd180 - d;
      end else if (d <= 9'd270) begin
         q = d - 9'd180;
         neg = 1'b1;
      end else begin
         q = 9'd360 - d;
         neg = 1'b1;
      end
      rounded = 64'(v2dt_pkg::SIN_Q31[q[6:0]]) + (64'd1 << (30 - F));
      rounded = rounded >> (31 - F);
      mag = rounded[F:0];
      return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   // {flag, value} after clipping to the coordinate range
   function automatic logic [W:0] clip_coord(input logic signed [WIDE-1:0] v);
      if (v > COORD_MAX) begin
         return {1'b1, COORD_MAX[W-1:0]};
      end else if (v < COORD_MIN) begin
         return {1'b1, COORD_MIN[W-1:0]};
      end
      return {1'b0, v[W-1:0]};
   endfunction

   // configuration registers
   logic [2:0]           mode_ff, mode_in;
   logic [W-1:0]         param_x_ff, param_x_in;
   logic [W-1:0]         param_y_ff, param_y_in;
   logic [8:0]           angle_ff, angle_in;
   logic signed [F+1:0]  sin_ff, sin_in;
   logic signed [F+1:0]  cos_ff, cos_in;

   logic       csr_write;
   logic [8:0] angle_red;
   logic [8:0] angle_cos;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      mode_in    = mode_ff;
      param_x_in = param_x_ff;
      param_y_in = param_y_ff;
      angle_in   = angle_ff;
      sin_in     = sin_ff;
      cos_in     = cos_ff;
      angle_red  = (pwdata[8:0] >= 9'd360) ? pwdata[8:0] - 9'd360 : pwdata[8:0];
      angle_cos  = angle_red + 9'd90;
      if (angle_cos >= 9'd360) begin
         angle_cos = angle_cos - 9'd360;
      end
      if (csr_write) begin
         unique case (v2dt_pkg::csr_index_type'(paddr[3:2]))
            v2dt_pkg::CSR_MODE:    mode_in    = pwdata[2:0];
            v2dt_pkg::CSR_PARAM_X: param_x_in = pwdata[W-1:0];
            v2dt_pkg::CSR_PARAM_Y: param_y_in = pwdata[W-1:0];
            v2dt_pkg::CSR_ANGLE: begin
               angle_in = pwdata[8:0];
               sin_in   = trig_sin(angle_red);
               cos_in   = trig_sin(angle_cos);
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (v2dt_pkg::csr_index_type'(paddr[3:2]))
         v2dt_pkg::CSR_MODE:    prdata = 32'(mode_ff);
         v2dt_pkg::CSR_PARAM_X: prdata = 32'(param_x_ff);
         v2dt_pkg::CSR_PARAM_Y: prdata = 32'(param_y_ff);
         v2dt_pkg::CSR_ANGLE:   prdata = 32'(angle_ff);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         param_x_ff <= '0;
         param_y_ff <= '0;
         angle_ff   <= '0;
         sin_ff     <= '0;
         cos_ff     <= TRIG_ONE;
      end else begin
         mode_ff    <= mode_in;
         param_x_ff <= param_x_in;
         param_y_ff <= param_y_in;
         angle_ff   <= angle_in;
         sin_ff     <= sin_in;
         cos_ff     <= cos_in;
      end
   end

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_advance;
   logic req_fire;

   logic signed [W-1:0] s1_vx_ff, s1_vy_ff;
   logic signed [W-1:0] rsp_out_x_ff, rsp_out_x_in;
   logic signed [W-1:0] rsp_out_y_ff, rsp_out_y_in;
   logic                rsp_saturated_ff, rsp_saturated_in;

   assign out_advance  = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !s1_valid_ff || out_advance;
   assign req_fire     = req_valid && req_ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !out_advance);
   assign rsp_valid_in = out_advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_vx_ff <= req_vx;
         s1_vy_ff <= req_vy;
      end
      if (out_advance && s1_valid_ff) begin
         rsp_out_x_ff     <= rsp_out_x_in;
         rsp_out_y_ff     <= rsp_out_y_in;
         rsp_saturated_ff <= rsp_saturated_in;
      end
   end

   // transform datapath
   logic signed [W-1:0]         px_s, py_s;
   logic signed [DX_BITS-1:0]   dx, dy;
   logic signed [PROD_BITS-1:0] prod_xc, prod_xs, prod_yc, prod_ys;
   logic signed [SUM_BITS-1:0]  rot_sum_x, rot_sum_y;
   logic signed [SUM_BITS-1:0]  rot_ceil_x, rot_ceil_y;
   logic signed [2*W-1:0]       scale_x, scale_y;
   logic signed [WIDE-1:0]      nx, ny;
   logic [W:0]                  clip_x, clip_y;

   assign px_s = param_x_ff;
   assign py_s = param_y_ff;
   assign dx   = DX_BITS'(s1_vx_ff) - DX_BITS'(px_s);
   assign dy   = DX_BITS'(s1_vy_ff) - DX_BITS'(py_s);

   assign prod_xc = dx * cos_ff;
   assign prod_xs = dx * sin_ff;
   assign prod_yc = dy * cos_ff;
   assign prod_ys = dy * sin_ff;

   assign rot_sum_x  = SUM_BITS'(prod_xc) - SUM_BITS'(prod_ys);
   assign rot_sum_y  = SUM_BITS'(prod_xs) + SUM_BITS'(prod_yc);
   assign rot_ceil_x = (rot_sum_x + CEIL_BIAS) >>> F;
   assign rot_ceil_y = (rot_sum_y + CEIL_BIAS) >>> F;

   assign scale_x = s1_vx_ff * px_s;
   assign scale_y = s1_vy_ff * py_s;

   always_comb begin
      nx = WIDE'(s1_vx_ff);
      ny = WIDE'(s1_vy_ff);
      case (mode_ff)
         v2dt_pkg::MODE_TRANSLATE: begin
            nx = WIDE'(s1_vx_ff) + WIDE'(px_s);
            ny = WIDE'(s1_vy_ff) + WIDE'(py_s);
         end
         v2dt_pkg::MODE_SCALE: begin
            nx = WIDE'(scale_x);
            ny = WIDE'(scale_y);
         end
         v2dt_pkg::MODE_ROTATE: begin
            nx = WIDE'(rot_ceil_x) + WIDE'(px_s);
            ny = WIDE'(rot_ceil_y) + WIDE'(py_s);
         end
         v2dt_pkg::MODE_REFLECT_H: begin
            ny = (WIDE'(py_s) + WIDE'(py_s)) - WIDE'(s1_vy_ff);
         end
         v2dt_pkg::MODE_REFLECT_V: begin
            nx = (WIDE'(px_s) + WIDE'(px_s)) - WIDE'(s1_vx_ff);
         end
         default: begin
            nx = WIDE'(s1_vx_ff);
            ny = WIDE'(s1_vy_ff);
         end
      endcase
   end

   assign clip_x           = clip_coord(nx);
   assign clip_y           = clip_coord(ny);
   assign rsp_out_x_in     = clip_x[W-1:0];
   assign rsp_out_y_in     = clip_y[W-1:0];
   assign rsp_saturated_in = clip_x[W] || clip_y[W];

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_out_x_ff;
   assign rsp_out_y     = rsp_out_y_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // a transaction leaving the input register always lands in the result register
   `V2DT_ASSERT_NEXT(a_pipe_move, clock, reset, s1_valid_ff && out_advance, rsp_valid_ff)
   // both stages full and stalled: no new vertex is taken
   `V2DT_ASSERT_IMPL(a_full_stall, clock, reset,
      s1_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready)
   // trig registers agree with the stored angle at the axis points
   `V2DT_ASSERT_IMPL(a_trig_zero, clock, reset, angle_ff == 9'd0,
      cos_ff == TRIG_ONE && sin_ff == '0)
   `V2DT_ASSERT_IMPL(a_trig_ninety, clock, reset, angle_ff == 9'd90,
      sin_ff == TRIG_ONE && cos_ff == '0)

endmodule

// ----- tb/tb_vertex_2d_transform.sv -----
// Self-checking testbench for vertex_2d_transform: directed table, then random vertices.
module tb_vertex_2d_transform;
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               sat;
   } vertex_out_type;

   typedef struct packed {
      bit                 load;
      logic [31:0]        mode_w;
      logic [31:0]        px_w;
      logic [31:0]        py_w;
      logic [31:0]        ang_w;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      bit                 typed;
      logic signed [15:0] ex;
      logic signed [15:0] ey;
      logic               es;
   } directed_row_type;

   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
   localparam int FRAC = 14;
   localparam int ROUND_SHIFT = 31 - FRAC;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_ITEMS_PER_PHASE = 545;
   localparam int NUM_DIRECTED = 24;

   localparam directed_row_type DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 16'sh7fff, 16'sh8000,
        1'b1, 16'sh7fff, 16'sh8000, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_TRANSLATE), 32'd1, 32'hffff_ffff, 32'd0, 16'sh7fff, 16'sh8000,
        1'b1, 16'sh7fff, 16'sh8000, 1'b1},
      '{1'b1, 32'(v2dt_pkg::MODE_TRANSLATE), 32'hffff_8000, 32'h7fff, 32'd0,
        16'sh8000, 16'sh7fff,
        1'b1, 16'sh8000, 16'sh7fff, 1'b1},
      '{1'b1, 32'(v2dt_pkg::MODE_TRANSLATE), 32'd100, -32'sd200, 32'd0, 16'sd5, 16'sd7,
        1'b1, 16'sd105, -16'sd193, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_SCALE), 32'd3, -32'sd2, 32'd0, 16'sd10, -16'sd20,
        1'b1, 16'sd30, 16'sd40, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_SCALE), 32'hffff_8000, 32'hffff_8000, 32'd0,
        16'sh8000, -16'sd1,
        1'b1, 16'sh7fff, 16'sh7fff, 1'b1},
      '{1'b1, 32'(v2dt_pkg::MODE_SCALE), 32'd0, 32'd0, 32'd0, 16'sd1234, -16'sd5,
        1'b1, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_SCALE), 32'h7fff, 32'h7fff, 32'd0, 16'sh7fff, 16'sh8000,
        1'b1, 16'sh7fff, 16'sh8000, 1'b1},
      '{1'b1, 32'(v2dt_pkg::MODE_ROTATE), 32'd0, 32'd0, 32'd0, 16'sd100, -16'sd50,
        1'b1, 16'sd100, -16'sd50, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_ROTATE), 32'd0, 32'd0, 32'd90, 16'sd100, 16'sd50,
        1'b1, -16'sd50, 16'sd100, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_ROTATE), 32'd10, 32'd10, 32'd180, 16'sd3, -16'sd4,
        1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_ROTATE), -32'sd100, 32'd200, 32'd45, 16'sd1000, -16'sd1000,
        1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_ROTATE), 32'h7fff, 32'h7fff, 32'd359, 16'sh8000, 16'sh8000,
        1'b0, 16'sd0, 16'sd0, 1'b0},
      // junk above each register's width, angle wraps past 360
      '{1'b1, 32'hffff_fff2, 32'h1234_0005, 32'hffff_fffb, 32'h0000_ff90, -16'sd7, 16'sd321,
        1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_ROTATE), 32'd0, 32'd0, 32'd511, 16'sh7fff, 16'sh7fff,
        1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_ROTATE), 32'd0, 32'd0, 32'd270, 16'sd0, 16'sh7fff,
        1'b0, 16'sd0, 16'sd0, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_REFLECT_H), 32'd0, 32'd100, 32'd0, 16'sd5, 16'sh8000,
        1'b1, 16'sd5, 16'sh7fff, 1'b1},
      '{1'b1, 32'(v2dt_pkg::MODE_REFLECT_H), 32'd0, 32'hffff_8000, 32'd0, 16'sd3, 16'sh7fff,
        1'b1, 16'sd3, 16'sh8000, 1'b1},
      '{1'b1, 32'(v2dt_pkg::MODE_REFLECT_H), 32'd99, 32'd7, 32'd0, 16'sd1, 16'sd2,
        1'b1, 16'sd1, 16'sd12, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_REFLECT_V), 32'h7fff, 32'd0, 32'd0, 16'sh8000, 16'sd9,
        1'b1, 16'sh7fff, 16'sd9, 1'b1},
      '{1'b1, 32'(v2dt_pkg::MODE_REFLECT_V), -32'sd5, 32'd0, 32'd0, 16'sd3, 16'sd4,
        1'b1, -16'sd13, 16'sd4, 1'b0},
      '{1'b1, 32'(MODE_UNUSED_LO), 32'd1, 32'd1, 32'd0, 16'sh8000, 16'sh7fff,
        1'b1, 16'sh8000, 16'sh7fff, 1'b0},
      '{1'b1, 32'(MODE_UNUSED_HI), 32'd5, 32'd5, 32'd77, 16'sd123, -16'sd456,
        1'b1, 16'sd123, -16'sd456, 1'b0},
      '{1'b1, 32'(v2dt_pkg::MODE_TRANSLATE), 32'hffff_8000, 32'h7fff, 32'd0, -16'sd1, -16'sd1,
        1'b1, 16'sh8000, 16'sd32766, 1'b1}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_vx;
   logic signed [15:0] req_vy;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic               rsp_saturated;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [3:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   logic [2:0]         cfg_mode;
   logic signed [15:0] cfg_px;
   logic signed [15:0] cfg_py;
   logic [8:0]         cfg_angle;

   vertex_out_type     predicted_vertices[$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 send_idle_pct;
   int                 recv_idle_pct;
   logic               hold_off_go;
   logic               hold_off_done = 1'b0;
   int                 hold_cycles_left = 0;

   vertex_2d_transform uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_vx        (req_vx),
      .req_vy        (req_vy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_saturated (rsp_saturated),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #6 clock = ~clock;

   // ---------------- predictor ----------------

   // Q31 sine of q in 0..90 degrees, Taylor series with truncating steps
   function automatic u64_type quadrant_sine_q31(int unsigned q);
      bit          use_cos;
      int unsigned r;
      u64_type     x;
      u64_type     term;
      u64_type     div;
      longint      sum;
      use_cos = (q > 45);
      r = use_cos ? 90 - q : q;
      x = (u64_type'(r) * v2dt_pkg::PI_Q31) / 180;
      term = use_cos ? v2dt_pkg::Q31_ONE : x;
      sum = longint'(term);
      for (int n = 1; n <= 6; n++) begin
         div = use_cos ? u64_type'((2 * n - 1) * (2 * n)) : u64_type'((2 * n) * (2 * n + 1));
         term = ((((term * x) >> 31) * x) >> 31) / div;
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return u64_type'(sum);
   endfunction

   function automatic longint degree_sine(int unsigned d);
      int unsigned q;
      bit          neg;
      u64_type     v;
      neg = 1'b0;
      if (d <= 90) begin
         q = d;
      end else if (d <= 180) begin
         q = 180 - d;
      end else if (d <= 270) begin
         q = d - 180;
         neg = 1'b1;
      end else begin
         q = 360 - d;
         neg = 1'b1;
      end
      v = (quadrant_sine_q31(q) + (u64_type'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      return neg ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint ceil_frac(longint v);
      if (v >= 0) begin
         return (v + (longint'(1) << FRAC) - 1) >>> FRAC;
      end
      return -((-v) >>> FRAC);
   endfunction

   // {clipped, value}
   function automatic logic [16:0] clamp_coord(longint v);
      if (v > 32767) begin
         return {1'b1, 16'h7fff};
      end
      if (v < -32768) begin
         return {1'b1, 16'h8000};
      end
      return {1'b0, v[15:0]};
   endfunction

   function automatic vertex_out_type transform_vertex(logic signed [15:0] vx,
                                                       logic signed [15:0] vy);
      longint         x, y, px, py, nx, ny, s, c, dx, dy;
      int unsigned    d;
      logic [16:0]    cx, cy;
      vertex_out_type r;
      x = longint'(vx);
      y = longint'(vy);
      px = longint'(cfg_px);
      py = longint'(cfg_py);
      nx = x;
      ny = y;
      case (cfg_mode)
         v2dt_pkg::MODE_TRANSLATE: begin
            nx = x + px;
            ny = y + py;
         end
         v2dt_pkg::MODE_SCALE: begin
            nx = x * px;
            ny = y * py;
         end
         v2dt_pkg::MODE_ROTATE: begin
            d = cfg_angle % 360;
            s = degree_sine(d);
            c = degree_sine((d + 90) % 360);
            dx = x - px;
            dy = y - py;
            nx = ceil_frac(dx * c - dy * s) + px;
            ny = ceil_frac(dx * s + dy * c) + py;
         end
         v2dt_pkg::MODE_REFLECT_H: begin
            ny = 2 * py - y;
         end
         v2dt_pkg::MODE_REFLECT_V: begin
            nx = 2 * px - x;
         end
         default: begin
         end
      endcase
      cx = clamp_coord(nx);
      cy = clamp_coord(ny);
      r.x = cx[15:0];
      r.y = cy[15:0];
      r.sat = cx[16] | cy[16];
      return r;
   endfunction

   // ---------------- drivers ----------------

   task automatic write_reg(v2dt_pkg::csr_index_type idx, logic [31:0] word);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         v2dt_pkg::CSR_MODE:    cfg_mode = word[2:0];
         v2dt_pkg::CSR_PARAM_X: cfg_px = word[15:0];
         v2dt_pkg::CSR_PARAM_Y: cfg_py = word[15:0];
         v2dt_pkg::CSR_ANGLE:   cfg_angle = word[8:0];
         default:     ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] mode_w, logic [31:0] px_w,
                            logic [31:0] py_w, logic [31:0] ang_w);
      write_reg(v2dt_pkg::CSR_MODE, mode_w);
      write_reg(v2dt_pkg::CSR_PARAM_X, px_w);
      write_reg(v2dt_pkg::CSR_PARAM_Y, py_w);
      write_reg(v2dt_pkg::CSR_ANGLE, ang_w);
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_vertices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                              vertex_out_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vx <= x;
      req_vy <= y;
      do @(posedge clock); while (!req_ready);
      predicted_vertices.push_back(want);
   endtask

   function automatic logic [15:0] pick_coord();
      int k;
      k = $urandom_range(99);
      if (k < 45) begin
         return 16'($urandom);
      end else if (k < 80) begin
         return 16'(int'($urandom_range(600)) - 300);
      end
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'hffff;
      endcase
   endfunction

   function automatic logic [8:0] pick_angle();
      int k;
      k = $urandom_range(99);
      if (k < 60) begin
         return 9'($urandom_range(359));
      end else if (k < 85) begin
         case ($urandom_range(4))
            0: return 9'd0;
            1: return 9'd90;
            2: return 9'd180;
            3: return 9'd270;
            default: return 9'd359;
         endcase
      end
      return 9'($urandom_range(511, 360));
   endfunction

   // ---------------- receiver and checker ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles_left != 0) begin
         rsp_ready <= 1'b0;
         hold_cycles_left <= hold_cycles_left - 1;
      end else if (hold_off_go && !hold_off_done) begin
         rsp_ready <= 1'b0;
         hold_cycles_left <= HOLD_OFF_CYCLES;
         hold_off_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      vertex_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_vertices.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transaction x=%0d y=%0d sat=%0b", $time,
                     rsp_out_x, rsp_out_y, rsp_saturated);
         end else begin
            want = predicted_vertices.pop_front();
            if (rsp_out_x !== want.x) begin
               mismatch_count++;
               $display("%0t: out_x expected %0d actual %0d", $time, want.x, rsp_out_x);
            end
            if (rsp_out_y !== want.y) begin
               mismatch_count++;
               $display("%0t: out_y expected %0d actual %0d", $time, want.y, rsp_out_y);
            end
            if (rsp_saturated !== want.sat) begin
               mismatch_count++;
               $display("%0t: saturated expected %0b actual %0b", $time, want.sat,
                        rsp_saturated);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("vertex_2d_transform regression: fail");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   initial begin
      directed_row_type   row;
      vertex_out_type     want;
      logic [31:0]        mode_w, px_w, py_w, ang_w;
      logic [2:0]         m;
      logic signed [15:0] x, y;
      int                 items_left;
      int                 burst;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_vx = '0;
      req_vy = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_mode = v2dt_pkg::MODE_TRANSLATE;
      cfg_px = '0;
      cfg_py = '0;
      cfg_angle = '0;
      send_idle_pct = 30;
      recv_idle_pct = 56;
      hold_off_go = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.load) begin
            settle_idle();
            configure(row.mode_w, row.px_w, row.py_w, row.ang_w);
         end
         if (row.typed) begin
            want.x = row.ex;
            want.y = row.ey;
            want.sat = row.es;
         end else begin
            want = transform_vertex(row.vx, row.vy);
         end
         send_vertex(row.vx, row.vy, want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         items_left = RANDOM_ITEMS_PER_PHASE;
         while (items_left > 0) begin
            settle_idle();
            if ($urandom_range(99) < 10) begin
               m = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
            end else begin
               m = 3'($urandom_range(v2dt_pkg::MODE_REFLECT_V, v2dt_pkg::MODE_TRANSLATE));
            end
            mode_w = $urandom;
            mode_w[2:0] = m;
            px_w = $urandom;
            px_w[15:0] = pick_coord();
            py_w = $urandom;
            py_w[15:0] = pick_coord();
            ang_w = $urandom;
            ang_w[8:0] = pick_angle();
            configure(mode_w, px_w, py_w, ang_w);
            // receiver holds off while the sender keeps pushing
            if (phase == 2) begin
               hold_off_go <= 1'b1;
            end
            burst = $urandom_range(60, 10);
            for (int k = 0; k < burst; k++) begin
               x = pick_coord();
               y = pick_coord();
               send_vertex(x, y, transform_vertex(x, y));
            end
            items_left = items_left - burst;
         end
      end

      settle_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && predicted_vertices.size() == 0) begin
         $display("vertex_2d_transform regression: pass");
      end else begin
         $display("vertex_2d_transform regression: fail");
      end
      $finish;
   end

endmodule
